@@ sv/aes256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_pkg
// shared types, s-box table and field helpers for the aes-256 round chain
// ----------------------------------------------------------------------------
package aes256_pkg;

    localparam int NUM_ROUNDS = 14;

    typedef struct packed {
        logic         zero;
        logic [255:0] key;
        logic [127:0] state;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

@@ sv/aes256_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_cell
// one cipher round plus the matching key expansion step, registered
// ----------------------------------------------------------------------------
module aes256_cell #(
    parameter int ROUND = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aes256_pkg::stage_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output aes256_pkg::stage_t  out_data
);

    localparam logic [7:0] RCON = 8'(1 << ((ROUND - 1) / 2));

    logic               valid_reg;
    aes256_pkg::stage_t data_reg;
    aes256_pkg::stage_t data_next;
    logic [127:0]       shifted;
    logic [127:0]       mixed;
    logic [127:0]       rkey;
    logic [31:0]        f_word;
    logic [31:0]        p7;
    logic [31:0]        n0, n1, n2, n3;
    logic [7:0]         a0, a1, a2, a3;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shifted[8*(4*c+r) +: 8] =
                    aes256_pkg::SBOX[in_data.state[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
    end

    always_comb
    begin
        mixed = shifted;
        if (ROUND < aes256_pkg::NUM_ROUNDS)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = shifted[32*c +: 8];
                a1 = shifted[32*c+8 +: 8];
                a2 = shifted[32*c+16 +: 8];
                a3 = shifted[32*c+24 +: 8];
                mixed[32*c +: 8]    = aes256_pkg::xtime(a0) ^ aes256_pkg::xtime(a1) ^ a1
                                      ^ a2 ^ a3;
                mixed[32*c+8 +: 8]  = a0 ^ aes256_pkg::xtime(a1) ^ aes256_pkg::xtime(a2)
                                      ^ a2 ^ a3;
                mixed[32*c+16 +: 8] = a0 ^ a1 ^ aes256_pkg::xtime(a2)
                                      ^ aes256_pkg::xtime(a3) ^ a3;
                mixed[32*c+24 +: 8] = aes256_pkg::xtime(a0) ^ a0 ^ a1 ^ a2
                                      ^ aes256_pkg::xtime(a3);
            end
        end
        else
        begin
            a0 = 8'h00;
            a1 = 8'h00;
            a2 = 8'h00;
            a3 = 8'h00;
        end
    end

    // key window holds words 4(round-1) .. 4round+3
    always_comb
    begin
        p7 = in_data.key[255:224];
        if ((ROUND % 2) == 1)
        begin
            f_word = aes256_pkg::sub_word({p7[7:0], p7[31:8]}) ^ {24'h0, RCON};
        end
        else
        begin
            f_word = aes256_pkg::sub_word(p7);
        end
        n0 = in_data.key[31:0] ^ f_word;
        n1 = in_data.key[63:32] ^ n0;
        n2 = in_data.key[95:64] ^ n1;
        n3 = in_data.key[127:96] ^ n2;
        rkey = in_data.zero ? 128'h0 : in_data.key[255:128];
        data_next.zero  = in_data.zero;
        data_next.key   = {n3, n2, n1, n0, in_data.key[255:128]};
        data_next.state = mixed ^ rkey;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/aes256_block_encrypt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_block_encrypt
// aes-256 encryption as a chain of fourteen round cells with on-the-fly keys
// ----------------------------------------------------------------------------
// channel   dir   handshake          payload
// s_axis    in    tvalid / tready    tdata = plain_low, plain_high
// m_axis    out   tvalid / tready    tdata = cipher_low, cipher_high
// cfg       in    cfg_we             cfg_index, cfg_data (key words)
//
// one key-whitening register, then one register per round
// one block per cycle unless stalled; each cell takes a transaction when it is
// empty or its neighbor takes one, so a stalled output fills the chain first
// reset clears valid bits and the key registers; until the first key write
// all round keys are zero
module aes256_block_encrypt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plain_low, plain_high
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_low, cipher_high
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int N = aes256_pkg::NUM_ROUNDS;

    logic [63:0]        key_reg [4];
    logic               keyed_reg;
    logic               v0_reg;
    aes256_pkg::stage_t d0_reg;
    aes256_pkg::stage_t d0_next;
    logic               ready0;
    logic               valid_c [N+1];
    logic               ready_c [N+1];
    aes256_pkg::stage_t data_c  [N+1];
    logic [255:0]       key_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 64'h0;
            end
            keyed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
            keyed_reg          <= 1'b1;
        end
    end

    always_comb
    begin
        key_all         = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
        d0_next.zero    = !keyed_reg;
        d0_next.key     = key_all;
        d0_next.state   = s_tdata ^ (keyed_reg ? key_all[127:0] : 128'h0);
    end

    assign ready0   = !v0_reg || ready_c[0];
    assign s_tready = ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ready0)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && s_tvalid)
        begin
            d0_reg <= d0_next;
        end
    end

    assign valid_c[0] = v0_reg;
    assign data_c[0]  = d0_reg;

    for (genvar g = 1; g <= N; g++)
    begin : g_round
        aes256_cell #(
            .ROUND (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[g-1]),
            .in_ready  (ready_c[g-1]),
            .in_data   (data_c[g-1]),
            .out_valid (valid_c[g]),
            .out_ready (ready_c[g]),
            .out_data  (data_c[g])
        );
    end

    assign ready_c[N] = m_tready;
    assign m_tvalid   = valid_c[N];
    assign m_tdata    = data_c[N].state;

endmodule

@@ sv/aes256_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_checker
// port-level checks on the aes-256 encrypt stream
// ----------------------------------------------------------------------------
module aes256_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

bind aes256_block_encrypt aes256_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
